FILE: rtl/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// types and constants shared by the sobel edge magnitude blocks
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int CHAN_W   = 8;
    localparam int PIX_W    = 3 * CHAN_W;
    localparam int FW_W     = 12;
    localparam int FH_W     = 16;
    localparam int CNT_W    = 32;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 22;
    localparam int ROOT_W   = 17;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic signed [GRAD_W-1:0] grad_t;

    typedef struct packed {
        logic              border;
        logic              frame_end;
        logic [PIX_W-1:0]  center;
        grad_t [2:0]       gv;
        grad_t [2:0]       gh;
    } entry_t;

    // p + 2q + r - s - 2t - u on 8-bit samples
    function automatic grad_t grad3(input logic [CHAN_W-1:0] p, input logic [CHAN_W-1:0] q,
                                    input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] s,
                                    input logic [CHAN_W-1:0] t, input logic [CHAN_W-1:0] u);
        grad_t sum;
        sum = grad_t'(p) + (grad_t'(q) <<< 1) + grad_t'(r)
            - grad_t'(s) - (grad_t'(t) <<< 1) - grad_t'(u);
        return sum;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/sem_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sem_div
    import sem_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  dividend,
    input  wire logic [FW_W-1:0]   divisor,
    output logic                   done,
    output logic [CNT_W-1:0]       quotient,
    output logic [FW_W-1:0]        remainder
);

    logic                    busy_reg;
    logic [4:0]              count_reg;
    logic [CNT_W-1:0]        quot_reg;
    logic [FW_W:0]           rem_reg;
    logic [FW_W-1:0]         div_reg;
    logic                    done_reg;
    logic [FW_W:0]           shifted;
    logic                    fits;

    assign shifted = {rem_reg[FW_W-1:0], quot_reg[CNT_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '1;
                quot_reg  <= dividend;
                rem_reg   <= '0;
                div_reg   <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? shifted - {1'b0, div_reg} : shifted;
                quot_reg <= {quot_reg[CNT_W-2:0], fits};
                count_reg <= count_reg - 5'd1;
                if (count_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[FW_W-1:0];

endmodule
`default_nettype wire

FILE: rtl/sem_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_fifo
// two-entry request queue between front and back
// ----------------------------------------------------------------------------
module sem_fifo
    import sem_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   wr,
    input  wire entry_t wr_data,
    output logic        is_full,
    input  wire logic   rd,
    output entry_t      rd_data,
    output logic        is_empty
);

    entry_t      mem_reg [2];
    logic        wptr_reg;
    logic        rptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign is_full  = count_reg == 2'd2;
    assign is_empty = count_reg == 2'd0;
    assign do_wr    = wr && !is_full;
    assign do_rd    = rd && !is_empty;
    assign rd_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sem_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_front
// line stores, window, gradient sums, position tracking and border classification
// ----------------------------------------------------------------------------
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [FW_W-1:0]   frame_width,
    input  wire logic [FH_W-1:0]   frame_height,
    input  wire logic              cfg_change,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [CHAN_W-1:0] red_in,
    input  wire logic [CHAN_W-1:0] green_in,
    input  wire logic [CHAN_W-1:0] blue_in,
    input  wire logic              drain,
    output logic                   q_wr,
    output entry_t                 q_data,
    input  wire logic              q_full
);

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {F_IDLE, F_UPDATE, F_DIVIDE, F_PUSH} state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   seen_reg;
    logic [AW-1:0]      col_reg;
    logic [AW-1:0]      addr_reg;
    logic [PIX_W-1:0]   pix_reg;
    logic [PIX_W-1:0]   up_rd_reg;
    logic [PIX_W-1:0]   mid_rd_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic [CNT_W-1:0]   q_reg;
    logic [CNT_W-1:0]   row_reg;
    logic [FW_W-1:0]    colq_reg;
    logic               pos_valid_reg;
    logic [PIX_W-1:0]   upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];

    logic [FW_W-1:0]        w_c;
    logic [FH_W-1:0]        h_c;
    logic [FW_W+FH_W-1:0]   total_p;
    logic [CNT_W-1:0]       total;
    logic                   flushing;
    logic                   accept;
    logic                   take;
    logic [AW-1:0]          col_sel;
    logic [CNT_W-1:0]       q_now;
    logic                   has_result;
    logic                   div_done;
    logic [CNT_W-1:0]       div_quot;
    logic [FW_W-1:0]        div_rem;
    logic                   is_end;
    logic                   is_border;

    always_comb
    begin
        if (frame_width < FW_W'(3))
            w_c = FW_W'(3);
        else if (32'(frame_width) > 32'(MAX_WIDTH))
            w_c = FW_W'(MAX_WIDTH);
        else
            w_c = frame_width;
        h_c = (frame_height < FH_W'(3)) ? FH_W'(3) : frame_height;
    end

    assign total_p    = (FW_W+FH_W)'(w_c) * (FW_W+FH_W)'(h_c);
    assign total      = CNT_W'(total_p);
    assign flushing   = seen_reg >= total;
    assign full       = state_reg != F_IDLE;
    assign accept     = push && !full;
    assign take       = accept && !(drain && !flushing);
    assign col_sel    = (32'(col_reg) < 32'(w_c)) ? col_reg : '0;
    assign q_now      = seen_reg - (CNT_W'(w_c) + CNT_W'(1));
    assign has_result = seen_reg >= CNT_W'(w_c) + CNT_W'(1);
    assign is_end     = q_reg >= total - CNT_W'(1);
    assign is_border  = (row_reg == '0) || (row_reg >= CNT_W'(h_c) - CNT_W'(1))
                     || (colq_reg == '0) || (colq_reg >= w_c - FW_W'(1));

    sem_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == F_UPDATE && has_result && !pos_valid_reg),
        .dividend  (q_now),
        .divisor   (w_c),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        q_data.border    = is_border;
        q_data.frame_end = is_end;
        q_data.center    = win_reg[1][1];
        for (int ch = 0; ch < 3; ch++)
        begin
            q_data.gv[ch] = grad3(win_reg[2][0][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[2][1][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[2][2][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[0][0][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[0][1][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[0][2][(2-ch)*CHAN_W +: CHAN_W]);
            q_data.gh[ch] = grad3(win_reg[0][2][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[1][2][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[2][2][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[0][0][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[1][0][(2-ch)*CHAN_W +: CHAN_W],
                                  win_reg[2][0][(2-ch)*CHAN_W +: CHAN_W]);
        end
    end

    assign q_wr = state_reg == F_PUSH && !q_full;

    // line stores
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            up_rd_reg  <= upper_mem[col_sel];
            mid_rd_reg <= middle_mem[col_sel];
        end
        if (state_reg == F_UPDATE)
        begin
            upper_mem[addr_reg]  <= mid_rd_reg;
            middle_mem[addr_reg] <= pix_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= F_IDLE;
            seen_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            colq_reg      <= '0;
            pos_valid_reg <= 1'b1;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_change)
            begin
                pos_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                F_IDLE:
                begin
                    if (take)
                    begin
                        pix_reg   <= flushing ? '0 : {red_in, green_in, blue_in};
                        addr_reg  <= col_sel;
                        state_reg <= F_UPDATE;
                    end
                end
                F_UPDATE:
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        win_reg[r][0] <= win_reg[r][1];
                        win_reg[r][1] <= win_reg[r][2];
                    end
                    win_reg[0][2] <= up_rd_reg;
                    win_reg[1][2] <= mid_rd_reg;
                    win_reg[2][2] <= pix_reg;
                    if (32'(addr_reg) + 32'd1 >= 32'(w_c))
                        col_reg <= '0;
                    else
                        col_reg <= addr_reg + AW'(1);
                    seen_reg <= seen_reg + CNT_W'(1);
                    q_reg    <= q_now;
                    if (!has_result)
                        state_reg <= F_IDLE;
                    else if (pos_valid_reg)
                        state_reg <= F_PUSH;
                    else
                        state_reg <= F_DIVIDE;
                end
                F_DIVIDE:
                begin
                    if (div_done)
                    begin
                        row_reg       <= div_quot;
                        colq_reg      <= div_rem;
                        pos_valid_reg <= 1'b1;
                        state_reg     <= F_PUSH;
                    end
                end
                F_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= F_IDLE;
                        if (is_end)
                        begin
                            seen_reg      <= '0;
                            col_reg       <= '0;
                            row_reg       <= '0;
                            colq_reg      <= '0;
                            pos_valid_reg <= 1'b1;
                        end
                        else if (colq_reg + FW_W'(1) == w_c)
                        begin
                            colq_reg <= '0;
                            row_reg  <= row_reg + CNT_W'(1);
                        end
                        else
                        begin
                            colq_reg <= colq_reg + FW_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sem_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_back
// gradient squares, integer square root, border pass-through and result register
// ----------------------------------------------------------------------------
module sem_back
    import sem_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire entry_t            q_data,
    input  wire logic              q_empty,
    output logic                   q_rd,
    output logic                   empty,
    input  wire logic              pop,
    output logic [CHAN_W-1:0]      red_out,
    output logic [CHAN_W-1:0]      green_out,
    output logic [CHAN_W-1:0]      blue_out,
    output logic                   frame_end
);

    typedef enum logic [1:0] {B_IDLE, B_SQUARE, B_ROOT} state_t;

    state_t              state_reg;
    grad_t               gv_reg [3];
    grad_t               gh_reg [3];
    logic [SQ_W-1:0]     n_reg [3];
    logic [ROOT_W-1:0]   rem_reg [3];
    logic [ROOT_W-1:0]   res_reg [3];
    logic [2:0]          step_reg;
    logic                fe_reg;
    logic                out_valid_reg;
    logic [CHAN_W-1:0]   out_reg [3];
    logic                out_fe_reg;

    logic [ROOT_W-1:0]   rem_next [3];
    logic [ROOT_W-1:0]   res_next [3];
    logic [SQ_W-1:0]     sq_sum [3];
    logic                out_load;

    assign q_rd     = state_reg == B_IDLE && !q_empty && (!out_valid_reg || pop);
    assign out_load = (q_rd && q_data.border) || (state_reg == B_ROOT && step_reg == 3'd0);

    always_comb
    begin
        logic [ROOT_W-1:0]            bitv;
        logic [ROOT_W-1:0]            trial;
        logic signed [2*GRAD_W-1:0]   pv;
        logic signed [2*GRAD_W-1:0]   ph;
        bitv = ROOT_W'(1) << {step_reg, 1'b0};
        for (int ch = 0; ch < 3; ch++)
        begin
            trial = res_reg[ch] + bitv;
            if (rem_reg[ch] >= trial)
            begin
                rem_next[ch] = rem_reg[ch] - trial;
                res_next[ch] = (res_reg[ch] >> 1) + bitv;
            end
            else
            begin
                rem_next[ch] = rem_reg[ch];
                res_next[ch] = res_reg[ch] >> 1;
            end
            pv = gv_reg[ch] * gv_reg[ch];
            ph = gh_reg[ch] * gh_reg[ch];
            sq_sum[ch] = SQ_W'(unsigned'(pv)) + SQ_W'(unsigned'(ph));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_rd)
                    begin
                        if (q_data.border)
                        begin
                            out_reg[0]    <= q_data.center[2*CHAN_W +: CHAN_W];
                            out_reg[1]    <= q_data.center[CHAN_W +: CHAN_W];
                            out_reg[2]    <= q_data.center[0 +: CHAN_W];
                            out_fe_reg    <= q_data.frame_end;
                        end
                        else
                        begin
                            for (int ch = 0; ch < 3; ch++)
                            begin
                                gv_reg[ch] <= q_data.gv[ch];
                                gh_reg[ch] <= q_data.gh[ch];
                            end
                            fe_reg    <= q_data.frame_end;
                            state_reg <= B_SQUARE;
                        end
                    end
                end
                B_SQUARE:
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        n_reg[ch]   <= sq_sum[ch];
                        rem_reg[ch] <= ROOT_W'(sq_sum[ch][15:0]);
                        res_reg[ch] <= '0;
                    end
                    step_reg  <= 3'd7;
                    state_reg <= B_ROOT;
                end
                B_ROOT:
                begin
                    for (int ch = 0; ch < 3; ch++)
                    begin
                        rem_reg[ch] <= rem_next[ch];
                        res_reg[ch] <= res_next[ch];
                    end
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0)
                    begin
                        // magnitudes of 256 and up saturate
                        for (int ch = 0; ch < 3; ch++)
                        begin
                            out_reg[ch] <= (n_reg[ch] >= SQ_W'(65536)) ? '1
                                                                        : res_next[ch][7:0];
                        end
                        out_fe_reg    <= fe_reg;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign empty     = !out_valid_reg;
    assign red_out   = out_reg[0];
    assign green_out = out_reg[1];
    assign blue_out  = out_reg[2];
    assign frame_end = out_fe_reg;

endmodule
`default_nettype wire

FILE: rtl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// a request goes through the front's update state, then its push state, into the queue; a border result
// is registered as the back reads it, an interior result after a read, a square state, then 8 root steps
// the front takes no new request until the last one is through (line store read, write, enqueue);
// the back takes a border request per cycle while results are popped, and no new request during
// the square and root steps; the first result after a geometry write waits for position division
// reset clears control, window and counters; line stores stay undefined until written
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 sobel gradient magnitude per rgb channel on a raster pixel stream
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic                   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   push,
    output logic                        full,
    input  wire logic [CHAN_W-1:0]      red_in,
    input  wire logic [CHAN_W-1:0]      green_in,
    input  wire logic [CHAN_W-1:0]      blue_in,
    input  wire logic                   drain,
    output logic                        empty,
    input  wire logic                   pop,
    output logic [CHAN_W-1:0]           red_out,
    output logic [CHAN_W-1:0]           green_out,
    output logic [CHAN_W-1:0]           blue_out,
    output logic                        frame_end
);

    logic [FW_W-1:0]  width_reg;
    logic [FH_W-1:0]  height_reg;
    logic             f_wr;
    entry_t           f_data;
    logic             q_full;
    logic             q_rd;
    entry_t           q_data;
    logic             q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= FW_W'(640);
            height_reg <= FH_W'(480);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg <= cfg_data[FH_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (width_reg),
        .frame_height (height_reg),
        .cfg_change   (cfg_write),
        .push         (push),
        .full         (full),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .drain        (drain),
        .q_wr         (f_wr),
        .q_data       (f_data),
        .q_full       (q_full)
    );

    sem_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (f_wr),
        .wr_data  (f_data),
        .is_full  (q_full),
        .rd       (q_rd),
        .rd_data  (q_data),
        .is_empty (q_empty)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_rd      (q_rd),
        .empty     (empty),
        .pop       (pop),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

endmodule
`default_nettype wire
